### design/gti_pkg.sv
// Shared constants and types for the gain table interpolator.
`timescale 1ns / 1ps
`default_nettype none
package gti_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	// quotient clamp: 2**QCAP_BITS
	localparam int QCAP_BITS = 40;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_FIN,
		ST_PUSH
	} state_t;

endpackage
`default_nettype wire

### design/gain_table_interpolator.sv
// Top level: per-pixel piecewise linear gain correction over streamed knots.
// A knot with no segment math returns to idle, or goes to the push state when it gives
// the result. A zero-width segment passes through the finish state, then push with a
// result. An interpolating knot runs the serial multiplier, then the serial divider,
// then the finish state, then push with a result; push waits on a full output register.
// Reset clears the FSM, output valid and the knot/held state to zero.
`timescale 1ns / 1ps
`default_nettype none
module gain_table_interpolator #(
	parameter int DATA_WIDTH = gti_pkg::DATA_WIDTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         item_valid,
	output logic                              item_ready,
	input  wire logic signed [DATA_WIDTH-1:0] sample,
	input  wire logic signed [DATA_WIDTH-1:0] knot_x,
	input  wire logic signed [DATA_WIDTH-1:0] knot_y,
	input  wire logic                         first_knot,
	input  wire logic                         last_knot,
	output logic                              result_valid,
	input  wire logic                         result_ready,
	output logic signed [DATA_WIDTH-1:0]      corrected,
	output logic                              zero_span
);
	import gti_pkg::*;

	localparam int W  = DATA_WIDTH;
	localparam int NW = 2 * W + 1;
	localparam int QW = (NW > QCAP_BITS + 1) ? NW : QCAP_BITS + 1;
	localparam int RW = ((W > QCAP_BITS + 1) ? W : QCAP_BITS + 1) + 2;
	localparam logic [QW-1:0] QCAP = QW'(1) << QCAP_BITS;
	localparam logic signed [RW-1:0] R_MAX = {{(RW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [RW-1:0] R_MIN = {{(RW-W+1){1'b1}}, {(W-1){1'b0}}};

	state_t state_q, state_d;

	logic signed [W-1:0] prev_x_q, prev_y_q, held_q;
	logic                resolved_q, held_zs_q;
	logic signed [W-1:0] y0_q, res_q, out_q;
	logic [W-1:0]        ud_q;
	logic                neg_q, dz_q, emit_q, zs_q, out_zs_q, out_valid_q;
	logic [QCAP_BITS:0]  qc_q;

	logic          accept, le, need_line, emit_direct, dzero, slot_free;
	logic [W:0]    dx, dd, dy, dx_n, dd_n, dy_n;
	logic [W-1:0]  mag_dx, mag_dy, mag_dd;
	logic          mul_start, mul_done, div_done;
	logic [2*W-1:0] prod;
	logic [NW-1:0] numer, quo;
	logic [QW-1:0] qx, qcap;
	logic signed [RW-1:0] r_ext;
	logic signed [W-1:0]  r_sat, r_sel;

	assign accept      = item_valid && item_ready;
	assign le          = sample <= knot_x;
	assign need_line   = !first_knot && !resolved_q && (last_knot || le);
	assign emit_direct = last_knot && !need_line;

	assign dx = {sample[W-1], sample} - {prev_x_q[W-1], prev_x_q};
	assign dd = {knot_x[W-1], knot_x} - {prev_x_q[W-1], prev_x_q};
	assign dy = {knot_y[W-1], knot_y} - {prev_y_q[W-1], prev_y_q};
	assign dx_n = ~dx + 1'b1;
	assign dd_n = ~dd + 1'b1;
	assign dy_n = ~dy + 1'b1;
	assign mag_dx = dx[W] ? dx_n[W-1:0] : dx[W-1:0];
	assign mag_dd = dd[W] ? dd_n[W-1:0] : dd[W-1:0];
	assign mag_dy = dy[W] ? dy_n[W-1:0] : dy[W-1:0];
	assign dzero  = dd == '0;

	assign numer = NW'(prod) + NW'(ud_q >> 1);
	assign qx    = QW'(quo);
	assign qcap  = (qx > QCAP) ? QCAP : qx;

	assign r_ext = neg_q ? (RW'(y0_q) - $signed(RW'(qc_q)))
	                     : (RW'(y0_q) + $signed(RW'(qc_q)));
	assign r_sat = (r_ext > R_MAX) ? W'(R_MAX) :
	               (r_ext < R_MIN) ? W'(R_MIN) : r_ext[W-1:0];
	assign r_sel = dz_q ? y0_q : r_sat;

	assign slot_free = !out_valid_q || result_ready;

	gti_serial_mult #(.W(W)) u_mult (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mag_dx),
		.b      (mag_dy),
		.done   (mul_done),
		.prod   (prod)
	);

	gti_serial_div #(.W(W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_done),
		.num    (numer),
		.den    (ud_q),
		.done   (div_done),
		.quo    (quo)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && need_line)
					state_d = dzero ? ST_FIN : ST_MUL;
				else if (accept && emit_direct)
					state_d = ST_PUSH;
			end
			ST_MUL:  if (mul_done) state_d = ST_DIV;
			ST_DIV:  if (div_done) state_d = ST_FIN;
			ST_FIN:  state_d = emit_q ? ST_PUSH : ST_IDLE;
			ST_PUSH: if (slot_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		item_ready = 1'b0;
		mul_start  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				mul_start  = item_valid && need_line && !dzero;
			end
			default: begin
				item_ready = 1'b0;
				mul_start  = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			held_q      <= '0;
			resolved_q  <= 1'b0;
			held_zs_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				prev_x_q <= knot_x;
				prev_y_q <= knot_y;
				if (first_knot) begin
					resolved_q <= le;
					if (le) begin
						held_q    <= knot_y;
						held_zs_q <= 1'b0;
					end
				end else if (need_line && !last_knot) begin
					resolved_q <= 1'b1;
				end
			end
			if (state_q == ST_FIN && !emit_q) begin
				held_q    <= r_sel;
				held_zs_q <= dz_q;
			end
			if (state_q == ST_PUSH && slot_free)
				out_valid_q <= 1'b1;
			else if (result_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			y0_q   <= prev_y_q;
			ud_q   <= mag_dd;
			neg_q  <= (dx[W] != dd[W]) != dy[W];
			dz_q   <= dzero;
			emit_q <= last_knot;
			if (emit_direct) begin
				res_q <= first_knot ? knot_y : held_q;
				zs_q  <= first_knot ? !le : held_zs_q;
			end
		end
		if (state_q == ST_DIV && div_done)
			qc_q <= qcap[QCAP_BITS:0];
		if (state_q == ST_FIN && emit_q) begin
			res_q <= r_sel;
			zs_q  <= dz_q;
		end
		if (state_q == ST_PUSH && slot_free) begin
			out_q    <= res_q;
			out_zs_q <= zs_q;
		end
	end

	assign result_valid = out_valid_q;
	assign corrected    = out_q;
	assign zero_span    = out_zs_q;
endmodule
`default_nettype wire

### design/gti_serial_mult.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module gti_serial_mult #(
	parameter int W = 32
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic [W-1:0]   a,
	input  wire logic [W-1:0]   b,
	output logic                done,
	output logic [2*W-1:0]      prod
);
	localparam int CW = $clog2(W);

	logic [W-1:0]   a_q;
	logic [2*W-1:0] prod_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [W:0]     sum;

	assign sum  = {1'b0, prod_q[2*W-1:W]} + (prod_q[0] ? {1'b0, a_q} : {(W+1){1'b0}});
	assign done = done_q;
	assign prod = prod_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q    <= a;
			prod_q <= {{W{1'b0}}, b};
		end else if (busy_q) begin
			prod_q <= {sum, prod_q[W-1:1]};
		end
	end
endmodule
`default_nettype wire

### design/gti_serial_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module gti_serial_div #(
	parameter int W = 32
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic [2*W:0]    num,
	input  wire logic [W-1:0]    den,
	output logic                 done,
	output logic [2*W:0]         quo
);
	localparam int NW = 2 * W + 1;
	localparam int CW = $clog2(NW);

	logic [NW-1:0] num_q;
	logic [NW-1:0] quo_q;
	logic [W-1:0]  den_q;
	logic [W-1:0]  rem_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    trial;
	logic [W:0]    diff;
	logic          ge;

	assign trial = {rem_q, num_q[NW-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};
	assign done  = done_q;
	assign quo   = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NW-2:0], 1'b0};
			rem_q <= ge ? diff[W-1:0] : trial[W-1:0];
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end
endmodule
`default_nettype wire

### design/gti_checker.sv
// Port-level checker for the gain table interpolator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module gti_checker #(
	parameter int DATA_WIDTH = gti_pkg::DATA_WIDTH_DEF
) (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         item_valid,
	input wire logic                         item_ready,
	input wire logic signed [DATA_WIDTH-1:0] knot_y,
	input wire logic                         first_knot,
	input wire logic                         last_knot,
	input wire logic                         result_valid,
	input wire logic                         result_ready,
	input wire logic signed [DATA_WIDTH-1:0] corrected,
	input wire logic                         zero_span
);
	logic single;
	assign single = item_valid && item_ready && first_knot && last_knot && !result_valid;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(corrected) && $stable(zero_span))
		else $error("result payload changed while stalled");

	a_single_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && first_knot && last_knot |=> !item_ready)
		else $error("knot taken while a result is being pushed");

	a_single_out: assert property (@(posedge clk) disable iff (!arst_n)
		single |-> ##2 result_valid)
		else $error("single-knot result late");

	a_single_val: assert property (@(posedge clk) disable iff (!arst_n)
		single |-> ##2 (corrected == $past(knot_y, 2)))
		else $error("single-knot result wrong");
endmodule

bind gain_table_interpolator gti_checker #(.DATA_WIDTH(DATA_WIDTH)) u_gti_checker (.*);
`default_nettype wire
